// File: rtl/cbs_pkg.sv
package cbs_pkg;

  // Fixed field widths of the request and result items.
  localparam int IN_W    = 10;
  localparam int GS_W    = 11;
  localparam int PEER_W  = 10;
  localparam int LEVEL_W = 4;

  // Default sizing of the schedule engine.
  localparam int MAX_GROUP_DEF  = 1024;
  localparam int MAX_LEVELS_DEF = 10;

  localparam logic [GS_W-1:0] GROUP_SIZE_RST = 11'd2;

  // Width of the shared compare-subtract unit: wide enough for the
  // group size shifted up by IN_W - 1 bits during the modulo reduction.
  localparam int UNIT_W = GS_W + IN_W - 1;

  typedef enum logic [1:0] {
    KIND_RECV = 2'd0,
    KIND_SEND = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [IN_W-1:0] my_rank;
    logic [IN_W-1:0] root_rank;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [PEER_W-1:0]  peer;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic              ge;
    logic [UNIT_W-1:0] diff;
  } csub_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEPTH,
    ST_SKIP,
    ST_MOD_ME,
    ST_MOD_ROOT,
    ST_REL,
    ST_WALK,
    ST_PLAN,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/cbs_csub.sv
module cbs_csub
  import cbs_pkg::*;
(
  input  logic [UNIT_W-1:0] a,
  input  logic [UNIT_W-1:0] b,
  output csub_res_t         res
);

  // One compare and one subtract, shared by the modulo, REL and WALK states.
  assign res.ge   = (a >= b);
  assign res.diff = a - b;

endmodule

// File: rtl/circulant_broadcast_schedule_core.sv
// Circulant broadcast schedule engine for one rank.
// A request on the in_ channel carries my_rank and root_rank. The engine
// works out which transfers that rank makes in a circulant-graph broadcast
// over a group of cfg_group_size ranks, and returns them on the out_
// channel: the single receive first (for a rank other than the root), then
// the sends in rising level order. The final result of a request has last
// set; a group below two ranks, or a rank with nothing to do, gives one
// result of kind "none".
//
// The user writes the group size through the cfg_ port only while the engine
// is idle; the block does not enforce it. The size resets to two, and reset
// clears the sequencer and drops any pending result.
// Set-up finds depth (ceil(log2(group_size)) capped at MAX_LEVELS), fills the
// skip table, reduces both ranks modulo the group size and forms the relative
// rank. The walk handles one skip level of one destination path per cycle on
// the shared compare-subtract unit, then a planning step and the results
// follow; a group below two ranks goes straight to its result. in_ready is
// high only while idle, which the sequencer reaches again once the last result
// is loaded into the output register. A stalled receiver holds that register
// and, with it, the emission of further results.
module circulant_broadcast_schedule_core
  import cbs_pkg::*;
#(
  parameter int MAX_GROUP  = MAX_GROUP_DEF,
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [GS_W-1:0] cfg_group_size
);

  // Index width of the skip table (entries 0 to MAX_LEVELS) and of the
  // per-level marks (entries 0 to MAX_LEVELS - 1).
  localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
  localparam int MIDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int JW     = $clog2(IN_W);
  localparam int PW     = GS_W + 1;

  state_t                state_r, state_nxt;
  logic [GS_W-1:0]       cfg_group_size_r;
  logic [GS_W-1:0]       n_r, n_nxt;
  logic [GS_W-1:0]       n_clamp;
  logic [IN_W-1:0]       me_r, me_nxt;
  logic [IN_W-1:0]       root_r, root_nxt;
  logic [GS_W-1:0]       rel_r, rel_nxt;
  logic [GS_W-1:0]       dst_r, dst_nxt;
  logic [GS_W-1:0]       hop_r, hop_nxt;
  logic [LVL_W-1:0]      depth_r, depth_nxt;
  logic [LVL_W-1:0]      k_r, k_nxt;
  logic [JW-1:0]         j_r, j_nxt;
  logic [MAX_LEVELS-1:0] recv_at_r, recv_at_nxt;
  logic [MAX_LEVELS-1:0] send_at_r, send_at_nxt;
  logic                  recv_pend_r, recv_pend_nxt;
  logic [LVL_W-1:0]      recv_lvl_r, recv_lvl_nxt;
  logic [MAX_LEVELS-1:0] send_pend_r, send_pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  // Skip table: a small register file with one read port.
  logic [GS_W-1:0]       skip_r [0:MAX_LEVELS];
  logic                  tbl_we;
  logic [LVL_W-1:0]      tbl_wa;
  logic [GS_W-1:0]       tbl_wd;
  logic [LVL_W-1:0]      rd_idx;
  logic [GS_W-1:0]       rd_data;

  logic [UNIT_W-1:0]     unit_a, unit_b;
  csub_res_t             unit_res;

  logic                  dst_done;
  logic                  is_last;

  // Lowest marked receive level, and the sends that lie above it.
  logic                  recv_any;
  logic [MIDX_W-1:0]     recv_low;
  logic [MAX_LEVELS-1:0] above_recv;
  logic                  send_any;
  logic [MIDX_W-1:0]     send_low;
  logic [MAX_LEVELS-1:0] send_low_bit;

  logic [PW-1:0]         recv_sum, send_sum, peer_sum;

  cbs_csub u_csub (
    .a   (unit_a),
    .b   (unit_b),
    .res (unit_res)
  );

  assign rd_data   = skip_r[rd_idx];
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A group size above the supported maximum is treated as the maximum.
  assign n_clamp = (32'(cfg_group_size_r) > 32'(MAX_GROUP)) ? GS_W'(MAX_GROUP)
                                                            : cfg_group_size_r;

  // Priority searches over the level marks, lowest level first.
  always_comb begin
    recv_any     = 1'b0;
    recv_low     = '0;
    send_any     = 1'b0;
    send_low     = '0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (recv_at_r[i]) begin
        recv_any = 1'b1;
        recv_low = MIDX_W'(i);
      end
      if (send_pend_r[i]) begin
        send_any = 1'b1;
        send_low = MIDX_W'(i);
      end
    end
    for (int i = 0; i < MAX_LEVELS; i++) begin
      above_recv[i]   = (MIDX_W'(i) > recv_low);
      send_low_bit[i] = (MIDX_W'(i) == send_low);
    end
  end

  // Peer ranks: a receive comes from the skip distance below this rank, a
  // send goes to the skip distance above it, both wrapped into the group.
  always_comb begin
    recv_sum = PW'(me_r) + PW'(n_r) - PW'(rd_data);
    send_sum = PW'(me_r) + PW'(rd_data);
    peer_sum = recv_pend_r ? recv_sum : send_sum;
    if (peer_sum >= PW'(n_r)) begin
      peer_sum = peer_sum - PW'(n_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    me_nxt        = me_r;
    root_nxt      = root_r;
    rel_nxt       = rel_r;
    dst_nxt       = dst_r;
    hop_nxt       = hop_r;
    depth_nxt     = depth_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    recv_at_nxt   = recv_at_r;
    send_at_nxt   = send_at_r;
    recv_pend_nxt = recv_pend_r;
    recv_lvl_nxt  = recv_lvl_r;
    send_pend_nxt = send_pend_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    unit_a        = '0;
    unit_b        = '0;
    tbl_we        = 1'b0;
    tbl_wa        = k_r;
    tbl_wd        = '0;
    rd_idx        = k_r;
    dst_done      = 1'b0;
    is_last       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          n_nxt         = n_clamp;
          me_nxt        = in_data.my_rank;
          root_nxt      = in_data.root_rank;
          recv_at_nxt   = '0;
          send_at_nxt   = '0;
          recv_pend_nxt = 1'b0;
          send_pend_nxt = '0;
          depth_nxt     = LVL_W'(1);
          // A group below two ranks goes straight to a "none" result.
          state_nxt     = (n_clamp < GS_W'(2)) ? ST_EMIT : ST_DEPTH;
        end
      end

      ST_DEPTH: begin
        if ((32'(depth_r) < 32'(MAX_LEVELS)) && ((32'd1 << depth_r) < 32'(n_r))) begin
          depth_nxt = depth_r + LVL_W'(1);
        end else begin
          tbl_we    = 1'b1;
          tbl_wa    = depth_r;
          tbl_wd    = n_r;
          k_nxt     = depth_r;
          state_nxt = ST_SKIP;
        end
      end

      ST_SKIP: begin
        if (k_r == '0) begin
          j_nxt     = JW'(IN_W - 1);
          state_nxt = ST_MOD_ME;
        end else begin
          tbl_we = 1'b1;
          tbl_wa = k_r - LVL_W'(1);
          tbl_wd = (rd_data >> 1) + GS_W'(rd_data[0]);
          k_nxt  = k_r - LVL_W'(1);
        end
      end

      ST_MOD_ME: begin
        unit_a = UNIT_W'(me_r);
        unit_b = UNIT_W'(n_r) << j_r;
        if (unit_res.ge) begin
          me_nxt = IN_W'(unit_res.diff);
        end
        if (j_r == '0) begin
          j_nxt     = JW'(IN_W - 1);
          state_nxt = ST_MOD_ROOT;
        end else begin
          j_nxt = j_r - JW'(1);
        end
      end

      ST_MOD_ROOT: begin
        unit_a = UNIT_W'(root_r);
        unit_b = UNIT_W'(n_r) << j_r;
        if (unit_res.ge) begin
          root_nxt = IN_W'(unit_res.diff);
        end
        if (j_r == '0) begin
          state_nxt = ST_REL;
        end else begin
          j_nxt = j_r - JW'(1);
        end
      end

      ST_REL: begin
        unit_a    = UNIT_W'(me_r);
        unit_b    = UNIT_W'(root_r);
        rel_nxt   = unit_res.ge ? GS_W'(unit_res.diff) : GS_W'(unit_res.diff) + n_r;
        dst_nxt   = GS_W'(1);
        hop_nxt   = GS_W'(1);
        k_nxt     = depth_r - LVL_W'(1);
        state_nxt = ST_WALK;
      end

      ST_WALK: begin
        unit_a = UNIT_W'(hop_r);
        unit_b = UNIT_W'(rd_data);
        if (unit_res.ge) begin
          if (hop_r == rel_r) begin
            recv_at_nxt[k_r[MIDX_W-1:0]] = 1'b1;
            dst_done = 1'b1;
          end else begin
            hop_nxt = GS_W'(unit_res.diff);
            if (GS_W'(unit_res.diff) == rel_r) begin
              send_at_nxt[k_r[MIDX_W-1:0]] = 1'b1;
            end
            dst_done = (k_r == '0);
          end
        end else begin
          dst_done = (k_r == '0);
        end
        if (dst_done) begin
          if (dst_r == n_r - GS_W'(1)) begin
            state_nxt = ST_PLAN;
          end else begin
            dst_nxt = dst_r + GS_W'(1);
            hop_nxt = dst_r + GS_W'(1);
            k_nxt   = depth_r - LVL_W'(1);
          end
        end else begin
          k_nxt = k_r - LVL_W'(1);
        end
      end

      ST_PLAN: begin
        if (rel_r != '0) begin
          recv_pend_nxt = recv_any;
          recv_lvl_nxt  = LVL_W'(recv_low);
          send_pend_nxt = recv_any ? (send_at_r & above_recv) : '0;
        end else begin
          send_pend_nxt = send_at_r;
        end
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (recv_pend_r) begin
            rd_idx        = recv_lvl_r;
            is_last       = (send_pend_r == '0);
            recv_pend_nxt = 1'b0;
            out_data_nxt.kind  = KIND_RECV;
            out_data_nxt.peer  = PEER_W'(peer_sum);
            out_data_nxt.level = LEVEL_W'(recv_lvl_r);
          end else if (send_any) begin
            rd_idx        = LVL_W'(send_low);
            is_last       = ((send_pend_r & ~send_low_bit) == '0);
            send_pend_nxt = send_pend_r & ~send_low_bit;
            out_data_nxt.kind  = KIND_SEND;
            out_data_nxt.peer  = PEER_W'(peer_sum);
            out_data_nxt.level = LEVEL_W'(send_low);
          end else begin
            is_last = 1'b1;
            out_data_nxt.kind  = KIND_NONE;
            out_data_nxt.peer  = '0;
            out_data_nxt.level = '0;
          end
          out_data_nxt.last = is_last;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      out_valid_r      <= 1'b0;
      recv_pend_r      <= 1'b0;
      send_pend_r      <= '0;
      cfg_group_size_r <= GROUP_SIZE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      recv_pend_r <= recv_pend_nxt;
      send_pend_r <= send_pend_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_group_size_r <= cfg_group_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    me_r       <= me_nxt;
    root_r     <= root_nxt;
    rel_r      <= rel_nxt;
    dst_r      <= dst_nxt;
    hop_r      <= hop_nxt;
    depth_r    <= depth_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    recv_at_r  <= recv_at_nxt;
    send_at_r  <= send_at_nxt;
    recv_lvl_r <= recv_lvl_nxt;
    out_data_r <= out_data_nxt;
    if (tbl_we) begin
      skip_r[tbl_wa] <= tbl_wd;
    end
  end

endmodule

// File: rtl/cbs_checker.sv
module cbs_checker
  import cbs_pkg::*;
#(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input out_item_t       out_data
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // The engine works on one request at a time.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in progress");

  // A "none" result is always alone and carries no peer or level.
  a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_NONE) |->
      out_data.last && (out_data.peer == '0) && (out_data.level == '0))
    else $error("malformed none result");

  // Transfers only happen at levels below the level bound.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.level) < MAX_LEVELS))
    else $error("result level beyond the level bound");

  // No result appears in the cycle after a request was taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared before the schedule was worked out");

endmodule

bind circulant_broadcast_schedule_core cbs_checker #(
  .MAX_LEVELS(MAX_LEVELS)
) u_cbs_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the circulant broadcast schedule engine.
//
// A driver process feeds requests to the in_ channel from a backlog that
// the stimulus process fills. Each accepted request is run through a
// predictor of the schedule under the group size that the bench last
// wrote, and the transfers it predicts are appended to a queue. A monitor
// process takes results from the out_ channel and compares them, field by
// field, with the oldest predicted transfer. The driver idles at random between
// requests, the monitor between results; some stretches run with none at all.
module tb_top;
  import cbs_pkg::*;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_item_t        in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [GS_W-1:0] cfg_group_size = GROUP_SIZE_RST;

  // Group size as the engine holds it, tracked from the writes we make.
  logic [GS_W-1:0] group_cfg = GROUP_SIZE_RST;

  in_item_t  query_backlog[$];
  out_item_t expected_transfers[$];

  int  send_gap = 0;
  int  recv_gap = 0;
  bit  quiet = 1'b0;
  int  fail_count = 0;

  // Long receiver hold-off: the stimulus bumps hold_trigger, and the
  // hold-off process below counts the stretch down on its own.
  int  hold_trigger = 0;
  int  hold_ack = 0;
  int  hold_left = 0;

  out_item_t want;

  circulant_broadcast_schedule_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_group_size (cfg_group_size)
  );

  always #4 clk = ~clk;

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int draw_gap();
    if (quiet) begin
      return 0;
    end
    return int'($urandom_range(0, 7));
  endfunction

  function automatic out_item_t transfer(kind_t kind, int unsigned peer,
                                         int unsigned lvl);
    out_item_t r;
    r.kind  = kind;
    r.peer  = PEER_W'(peer);
    r.level = LEVEL_W'(lvl);
    r.last  = 1'b0;
    return r;
  endfunction

  // Works out the transfers one rank makes for a request and appends them,
  // in the order the engine must return them, to expected_transfers.
  function automatic void plan_transfers(in_item_t q);
    int unsigned n, depth, me, root, rel, hop, i;
    int          lv, dst;
    int unsigned skip [0:MAX_LEVELS_DEF];
    bit          recv_lvl [0:MAX_LEVELS_DEF-1];
    bit          send_lvl [0:MAX_LEVELS_DEF-1];
    out_item_t   batch[$];

    n = group_cfg;
    if (n > MAX_GROUP_DEF) begin
      n = MAX_GROUP_DEF;
    end
    for (lv = 0; lv < MAX_LEVELS_DEF; lv++) begin
      recv_lvl[lv] = 1'b0;
      send_lvl[lv] = 1'b0;
    end

    if (n >= 2) begin
      depth = 1;
      while (depth < MAX_LEVELS_DEF && (1 << depth) < n) begin
        depth++;
      end
      // The top skip is the group itself; each one below is half the one
      // above, rounded up.
      skip[depth] = n;
      for (lv = int'(depth) - 1; lv >= 0; lv--) begin
        skip[lv] = (skip[lv+1] >> 1) + (skip[lv+1] & 1);
      end

      me   = q.my_rank % n;
      root = q.root_rank % n;
      rel  = (me + n - root) % n;

      // Walk the path to every destination, largest skip first. Where this
      // rank starts a hop it receives there; where a hop lands on it, it
      // sends at that level.
      for (dst = 1; dst < int'(n); dst++) begin
        hop = dst;
        for (lv = int'(depth) - 1; lv >= 0; lv--) begin
          if (hop >= skip[lv]) begin
            if (hop == rel) begin
              recv_lvl[lv] = 1'b1;
              break;
            end
            hop -= skip[lv];
            if (hop == rel) begin
              send_lvl[lv] = 1'b1;
            end
          end
        end
      end

      // A rank other than the root receives once, at its lowest receive
      // level, and then sends only above it. Without a receive it sends
      // nothing.
      i = 0;
      if (rel != 0) begin
        while (i < depth && !recv_lvl[i]) begin
          i++;
        end
        if (i < depth) begin
          batch.push_back(transfer(KIND_RECV, (me + n - skip[i]) % n, i));
          i++;
        end
      end
      while (i < depth) begin
        if (send_lvl[i]) begin
          batch.push_back(transfer(KIND_SEND, (me + skip[i]) % n, i));
        end
        i++;
      end
    end

    // A group under two ranks, or a rank with no transfer, gets a single
    // "nothing to do" result.
    if (batch.size() == 0) begin
      batch.push_back(transfer(KIND_NONE, 0, 0));
    end
    batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) begin
      expected_transfers.push_back(batch[k]);
    end
  endfunction

  // Request driver. A request is predicted at the edge where it is taken;
  // the next one is offered after its own random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        plan_transfers(in_data);
        send_gap = draw_gap();
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (query_backlog.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= query_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_trigger != hold_ack) begin
      hold_ack  <= hold_trigger;
      hold_left <= 300;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor. Every result taken is checked against the oldest
  // predicted transfer; the receiver then idles for its own random gap,
  // or for the whole of a long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_transfers.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: unexpected result kind=%0d peer=%0d level=%0d last=%0d",
                     $realtime, out_data.kind, out_data.peer, out_data.level,
                     out_data.last);
          end
        end else begin
          want = expected_transfers.pop_front();
          if (out_data.kind !== want.kind || out_data.peer !== want.peer ||
              out_data.level !== want.level || out_data.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch, expected kind=%0d peer=%0d level=%0d last=%0d,",
                       $realtime, want.kind, want.peer, want.level, want.last);
              $display("          got kind=%0d peer=%0d level=%0d last=%0d",
                       out_data.kind, out_data.peer, out_data.level, out_data.last);
            end
          end
        end
        recv_gap = draw_gap();
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus works at the falling edge so that it never races the driver,
  // apart from the configuration port, which it drives at the rising edge.
  function automatic void post_query(int unsigned my, int unsigned root);
    in_item_t it;
    it.my_rank   = IN_W'(my);
    it.root_rank = IN_W'(root);
    query_backlog.push_back(it);
  endfunction

  // Holds back until every request has gone and every result has come in.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (query_backlog.size() != 0 || in_valid || expected_transfers.size() != 0);
  endtask

  task automatic write_group_size(logic [GS_W-1:0] g);
    @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_group_size <= g;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
    group_cfg = g;
  endtask

  initial begin
    int unsigned g, my, root;
    int          j, k;

    wait (rst_n === 1'b1);
    @(negedge clk);

    // Group of two as it comes out of reset, ranks at both ends of the
    // field and out of range.
    post_query(0, 0);
    post_query(1, 0);
    post_query(0, 1);
    post_query(1023, 1023);
    post_query(1023, 0);
    drain();

    // Groups too small to broadcast in.
    write_group_size(GS_W'(0));
    post_query(5, 3);
    post_query(0, 0);
    drain();
    write_group_size(GS_W'(1));
    post_query(1023, 7);
    drain();

    // Largest group: root, far ends and neighbours, all ten levels in use.
    write_group_size(GS_W'(MAX_GROUP_DEF));
    post_query(0, 0);
    post_query(1023, 0);
    post_query(0, 1023);
    post_query(512, 511);
    post_query(1, 0);
    drain();

    // Oversized groups are clipped to the largest one.
    write_group_size(11'h7FF);
    post_query(1023, 1);
    post_query(7, 7);
    drain();
    write_group_size(GS_W'(MAX_GROUP_DEF + 1));
    post_query(1023, 0);
    drain();

    // Small group with the receiver held off for a long stretch while the
    // sender keeps offering, so that the engine backs up onto its input.
    write_group_size(GS_W'(5));
    quiet = 1'b1;
    hold_trigger++;
    post_query(1023, 1022);
    post_query(4, 0);
    post_query(3, 3);
    post_query(0, 4);
    post_query(9, 2);
    post_query(2, 9);
    drain();
    quiet = 1'b0;

    // Random phases: mostly small groups, one medium-sized one.
    for (j = 0; j < 12; j++) begin
      if (j == 5) begin
        g = $urandom_range(100, 260);
      end else begin
        g = $urandom_range(2, 48);
      end
      write_group_size(GS_W'(g));
      quiet = (j % 4 == 3);
      for (k = 0; k < 16; k++) begin
        my = $urandom_range(0, 1023);
        // A quarter of the requests ask for the root's own schedule.
        if ($urandom_range(0, 3) == 0) begin
          root = my;
        end else begin
          root = $urandom_range(0, 1023);
        end
        post_query(my, root);
      end
      drain();
    end
    quiet = 1'b0;

    // Give the engine time to put out anything it should not.
    repeat (64) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && expected_transfers.size() == 0) begin
      $display("PASS circulant_broadcast_schedule_core");
    end else begin
      $display("FAIL circulant_broadcast_schedule_core");
    end
    $finish;
  end

  // Timeout for a run that hangs; it allows for several times the worst case of
  // every request at its slowest.
  initial begin
    #20_000_000;
    $display("FAIL circulant_broadcast_schedule_core");
    $finish;
  end

endmodule

// File: filelist.f
rtl/cbs_pkg.sv
rtl/cbs_csub.sv
rtl/circulant_broadcast_schedule_core.sv
rtl/cbs_checker.sv
tb/tb_top.sv
